[rtl/core/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Software timer table package
// Types, codes and constants shared by the timer table controller and its
// entry memory.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned MAX_TABLE      = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned DATA_W         = 8;

  localparam logic [TIME_W-1:0] NO_DEADLINE = 32'hffff_ffff;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_ALLOC   = 3'd1;
  localparam logic [2:0] KIND_FREE    = 3'd2;
  localparam logic [2:0] KIND_INIT    = 3'd3;
  localparam logic [2:0] KIND_SETTIME = 3'd4;

  localparam logic RES_ALLOC  = 1'b0;
  localparam logic RES_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_ARMED = 2'd2
  } status_e;

  typedef struct packed {
    logic              status_en;
    logic              deadline_en;
    logic              data_en;
    logic [IDX_W-1:0]  addr;
    status_e           status;
    logic [TIME_W-1:0] deadline;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] deadline;
    logic [DATA_W-1:0] data;
  } rd_rsp_t;

endpackage

[rtl/core/stt_table.sv]
// ----------------------------------------------------------------------------
// Timer entry memory
// Synchronous memory holding status, deadline and data of each timer entry,
// with one write port, one registered read port and a valid bit per entry so
// that entries read as free after reset.
// ----------------------------------------------------------------------------
module stt_table
  import stt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = MAX_TABLE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wr_req_t          wr_req_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output rd_rsp_t          rd_rsp_o
);

  localparam int unsigned IdxW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  status_e           status_mem   [TABLE_SIZE];
  logic [TIME_W-1:0] deadline_mem [TABLE_SIZE];
  logic [DATA_W-1:0] data_mem     [TABLE_SIZE];

  logic [TABLE_SIZE-1:0] valid_q;
  logic                  rd_valid_q;
  status_e               rd_status_q;
  logic [TIME_W-1:0]     rd_deadline_q;
  logic [DATA_W-1:0]     rd_data_q;
  logic [IdxW-1:0]       wr_addr;
  logic [IdxW-1:0]       rd_addr;

  assign wr_addr = wr_req_i.addr[IdxW-1:0];
  assign rd_addr = rd_addr_i[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_req_i.status_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_req_i.status_en) begin
      status_mem[wr_addr] <= wr_req_i.status;
    end
    if (wr_req_i.deadline_en) begin
      deadline_mem[wr_addr] <= wr_req_i.deadline;
    end
    if (wr_req_i.data_en) begin
      data_mem[wr_addr] <= wr_req_i.data;
    end
    if (rd_en_i) begin
      rd_status_q   <= status_mem[rd_addr];
      rd_deadline_q <= deadline_mem[rd_addr];
      rd_data_q     <= data_mem[rd_addr];
    end
  end

  assign rd_rsp_o.status   = rd_valid_q ? rd_status_q : ST_FREE;
  assign rd_rsp_o.deadline = rd_deadline_q;
  assign rd_rsp_o.data     = rd_data_q;

  // The controller never reads an entry in the cycle it writes it.
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && (wr_req_i.status_en || wr_req_i.deadline_en || wr_req_i.data_en)
    |-> wr_req_i.addr != rd_addr_i)
    else $error("read and write address the same entry");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> {1'b0, rd_addr_i} < (IDX_W + 1)'(TABLE_SIZE))
    else $error("read address beyond the table");

  a_wr_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req_i.status_en |=> valid_q[$past(wr_addr)])
    else $error("status write did not mark the entry valid");

endmodule

[rtl/core/software_timer_table.sv]
// ----------------------------------------------------------------------------
// Software timer table
// Table of timers with a free-running tick count and the earliest pending
// deadline; allocates entries and reports expired timers in index order.
// ----------------------------------------------------------------------------
// Free, init, set time and a tick before the deadline never raise busy. An
// alloc reads the entries one per cycle from the entry memory and replies when
// it finds a free entry or reaches the last one; busy drops with the reply.
// A deadline tick scans all entries through the memory read port, one a cycle,
// then flushes before busy drops; at most one result appears a cycle.
// After reset all entries are free, the count is zero and the deadline is all
// ones, at once. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module software_timer_table
  import stt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [IDX_W-1:0]  timer_index_i,
  input  logic [TIME_W-1:0] timeout_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              result_valid_o,
  output logic              result_kind_o,
  output logic [IDX_W-1:0]  timer_index_res_o,
  output logic [DATA_W-1:0] data_res_o,
  output logic              alloc_failed_o,
  output logic              last_o
);

  localparam int unsigned TableSize = (NUM_TIMERS < MAX_TABLE) ? NUM_TIMERS : MAX_TABLE;
  localparam int unsigned IdxW      = (TableSize > 1) ? $clog2(TableSize) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic              op_alloc_q, op_alloc_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic [TIME_W-1:0] nd_q, nd_d;
  logic              pend_v_q, pend_v_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic [DATA_W-1:0] pend_data_q, pend_data_d;
  logic              res_v_q, res_v_d;
  logic              res_kind_q, res_kind_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              res_fail_q, res_fail_d;
  logic              res_last_q, res_last_d;

  wr_req_t           wr_req;
  rd_rsp_t           rd_rsp;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] tick_inc;
  logic [TIME_W-1:0] set_dl;
  logic              in_table;
  logic              last_entry;
  logic [IdxW-1:0]   cnt_nxt;

  assign busy     = (state_q != S_IDLE);
  assign tick_inc = tick_q + 32'd1;
  assign set_dl   = timeout_i + tick_q;
  assign in_table = {1'b0, timer_index_i} < (IDX_W + 1)'(TableSize);
  assign cnt_nxt  = cnt_q + IdxW'(1);
  assign last_entry = (cnt_q == IdxW'(TableSize - 1));

  always_comb begin
    state_d     = state_q;
    op_alloc_d  = op_alloc_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    nd_d        = nd_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    pend_data_d = pend_data_q;
    res_v_d     = 1'b0;
    res_kind_d  = res_kind_q;
    res_idx_d   = res_idx_q;
    res_data_d  = res_data_q;
    res_fail_d  = res_fail_q;
    res_last_d  = res_last_q;
    wr_req      = '0;
    wr_req.addr = timer_index_i;
    rd_en       = 1'b0;
    rd_addr     = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_TICK: begin
              tick_d = tick_inc;
              if (!(nd_q > tick_inc)) begin
                nd_d       = NO_DEADLINE;
                state_d    = S_SCAN;
                op_alloc_d = 1'b0;
                cnt_d      = '0;
                pend_v_d   = 1'b0;
                rd_en      = 1'b1;
              end
            end
            KIND_ALLOC: begin
              state_d    = S_SCAN;
              op_alloc_d = 1'b1;
              cnt_d      = '0;
              rd_en      = 1'b1;
            end
            KIND_FREE: begin
              wr_req.status_en = in_table;
              wr_req.status    = ST_FREE;
            end
            KIND_INIT: begin
              wr_req.data_en = in_table;
              wr_req.data    = data_i;
            end
            KIND_SETTIME: begin
              wr_req.status_en   = in_table;
              wr_req.deadline_en = in_table;
              wr_req.status      = ST_ARMED;
              wr_req.deadline    = set_dl;
              if (in_table && (nd_q > set_dl)) begin
                nd_d = set_dl;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_d       = cnt_nxt;
        wr_req.addr = IDX_W'(cnt_q);
        if (!last_entry) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cnt_nxt);
        end
        if (op_alloc_q) begin
          if (rd_rsp.status == ST_FREE) begin
            wr_req.status_en = 1'b1;
            wr_req.status    = ST_ALLOC;
            res_v_d    = 1'b1;
            res_kind_d = RES_ALLOC;
            res_idx_d  = IDX_W'(cnt_q);
            res_data_d = '0;
            res_fail_d = 1'b0;
            res_last_d = 1'b1;
            state_d    = S_IDLE;
          end else if (last_entry) begin
            res_v_d    = 1'b1;
            res_kind_d = RES_ALLOC;
            res_idx_d  = '0;
            res_data_d = '0;
            res_fail_d = 1'b1;
            res_last_d = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          if (rd_rsp.status == ST_ARMED) begin
            if (rd_rsp.deadline <= tick_q) begin
              wr_req.status_en = 1'b1;
              wr_req.status    = ST_ALLOC;
              if (pend_v_q) begin
                res_v_d    = 1'b1;
                res_kind_d = RES_EXPIRY;
                res_idx_d  = pend_idx_q;
                res_data_d = pend_data_q;
                res_fail_d = 1'b0;
                res_last_d = 1'b0;
              end
              pend_v_d    = 1'b1;
              pend_idx_d  = IDX_W'(cnt_q);
              pend_data_d = rd_rsp.data;
            end else if (nd_q > rd_rsp.deadline) begin
              nd_d = rd_rsp.deadline;
            end
          end
          if (last_entry) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          res_v_d    = 1'b1;
          res_kind_d = RES_EXPIRY;
          res_idx_d  = pend_idx_q;
          res_data_d = pend_data_q;
          res_fail_d = 1'b0;
          res_last_d = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_alloc_q  <= 1'b0;
      cnt_q       <= '0;
      tick_q      <= '0;
      nd_q        <= NO_DEADLINE;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      pend_data_q <= '0;
      res_v_q     <= 1'b0;
      res_kind_q  <= RES_ALLOC;
      res_idx_q   <= '0;
      res_data_q  <= '0;
      res_fail_q  <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_alloc_q  <= op_alloc_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      nd_q        <= nd_d;
      pend_v_q    <= pend_v_d;
      pend_idx_q  <= pend_idx_d;
      pend_data_q <= pend_data_d;
      res_v_q     <= res_v_d;
      res_kind_q  <= res_kind_d;
      res_idx_q   <= res_idx_d;
      res_data_q  <= res_data_d;
      res_fail_q  <= res_fail_d;
      res_last_q  <= res_last_d;
    end
  end

  stt_table #(
    .TABLE_SIZE (TableSize)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_req_i  (wr_req),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_rsp_o  (rd_rsp)
  );

  assign result_valid_o    = res_v_q;
  assign result_kind_o     = res_kind_q;
  assign timer_index_res_o = res_idx_q;
  assign data_res_o        = res_data_q;
  assign alloc_failed_o    = res_fail_q;
  assign last_o            = res_last_q;

  // An alloc always starts a scan, so the block is busy in the next cycle.
  a_alloc_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KIND_ALLOC) |=> busy)
    else $error("alloc transaction did not start a scan");

  a_alloc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == RES_ALLOC) |-> last_o && !busy)
    else $error("alloc reply not final or block still busy");

  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && alloc_failed_o
    |-> (result_kind_o == RES_ALLOC) && (timer_index_res_o == '0))
    else $error("malformed failed alloc reply");

endmodule
